// ===== src/maes_pkg.sv =====
package maes_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
	localparam logic [2:0] REG_KEY_LOW   = 3'd1;
	localparam logic [2:0] REG_MASK_IN   = 3'd2;
	localparam logic [2:0] REG_MASK_OUT  = 3'd3;
	localparam logic [2:0] REG_ROW_MASKS = 3'd4;

	// reset values of the registers
	localparam logic [63:0] KEY_HIGH_RST  = 64'h8000000000000000;
	localparam logic [63:0] KEY_LOW_RST   = 64'h0;
	localparam logic [7:0]  MASK_IN_RST   = 8'h2d;
	localparam logic [7:0]  MASK_OUT_RST  = 8'ha5;
	localparam logic [31:0] ROW_MASKS_RST = 32'h177e85b8;

	localparam logic [7:0] GF_POLY = 8'h1b;
	localparam logic [3:0] LAST_ROUND = 4'd9;

	typedef logic [3:0][7:0] col_t;
	typedef logic [15:0][7:0] blk_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	// masked s-box: maps v^mi to S(v)^mo
	function automatic logic [7:0] sbox_m(input logic [7:0] x, input logic [7:0] mi,
		input logic [7:0] mo);
		return SBOX[x ^ mi] ^ mo;
	endfunction

	// round constant for the key word generated after the given round
	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] v;
		case (rnd)
			4'd0: v = 8'h01;
			4'd1: v = 8'h02;
			4'd2: v = 8'h04;
			4'd3: v = 8'h08;
			4'd4: v = 8'h10;
			4'd5: v = 8'h20;
			4'd6: v = 8'h40;
			4'd7: v = 8'h80;
			4'd8: v = 8'h1b;
			4'd9: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	// mixcolumns on one column, row zero at index zero
	function automatic col_t mix_col(input col_t a);
		col_t d;
		col_t c;
		for (int k = 0; k < 4; k++) d[k] = gf_double(a[k]);
		for (int k = 0; k < 4; k++) begin
			c[k] = d[k] ^ d[(k + 1) % 4] ^ a[(k + 1) % 4] ^ a[(k + 2) % 4] ^ a[(k + 3) % 4];
		end
		return c;
	endfunction

endpackage

// ===== src/masked_aes128_encrypt_unit.sv =====
// Boolean-masked AES-128 encryption, one 128-bit block per request. A request
// is taken in a cycle where the round unit is idle, then the block runs all
// ten rounds in the round unit (one shared round datapath with its on-the-fly
// masked key expansion, reused once per round; the last round also adds the
// final round key). The result lands in the output register at the edge that
// ends the last round, and in_stall drops at that same edge, so a new block
// can be taken only once the previous one has left the round unit.
// in_stall stays high while a block is in the round unit; a new block may be
// taken while a finished one still waits at the output, and the round unit
// then holds in its last round until the output register is free.
// The user must write key and masks through cfg only while idle; it is not enforced.
module masked_aes128_encrypt_unit import maes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t      state_q;
	logic [3:0]  rnd_q;
	blk_t        st_q;
	blk_t        rk_q;
	logic        out_valid_q;
	logic [63:0] cipher_high_q;
	logic [63:0] cipher_low_q;
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [7:0]  mask_in_q;
	logic [7:0]  mask_out_q;
	logic [31:0] row_masks_q;

	col_t mt;
	col_t mtp;
	blk_t in_blk;
	blk_t key0;
	blk_t ak;
	blk_t ss;
	blk_t nk;
	blk_t mixed;
	blk_t fin;
	col_t kt;
	col_t mcol;
	logic in_acc;
	logic out_acc;
	logic last;
	logic done;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign last    = (rnd_q == LAST_ROUND);
	assign done    = (state_q == S_RUN) && last && (!out_valid_q || !out_stall);

	assign in_stall    = (state_q == S_RUN);
	assign out_valid   = out_valid_q;
	assign cipher_high = cipher_high_q;
	assign cipher_low  = cipher_low_q;

	// row masks and their mixcolumns image
	always_comb begin
		for (int r = 0; r < 4; r++) mt[r] = row_masks_q[31 - 8 * r -: 8];
		mtp = mix_col(mt);
	end

	// masked load of plaintext and initial round key
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			if (k < 8) begin
				in_blk[(k % 4) * 4 + k / 4] = plain_high[63 - 8 * k -: 8] ^ mtp[k % 4];
				key0[k] = key_high_q[63 - 8 * k -: 8] ^ mtp[k % 4] ^ mask_in_q;
			end else begin
				in_blk[(k % 4) * 4 + k / 4] = plain_low[63 - 8 * (k - 8) -: 8] ^ mtp[k % 4];
				key0[k] = key_low_q[63 - 8 * (k - 8) -: 8] ^ mtp[k % 4] ^ mask_in_q;
			end
		end
	end

	// next masked round key
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			kt[j] = sbox_m(rk_q[12 + (j + 1) % 4] ^ mtp[(j + 1) % 4], mask_in_q, mask_out_q);
		end
		kt[0] = kt[0] ^ rcon(rnd_q);
		for (int j = 0; j < 4; j++) begin
			nk[j] = rk_q[j] ^ kt[j] ^ (last ? (mask_in_q ^ mtp[j]) : mask_out_q);
		end
		for (int w = 1; w < 4; w++) begin
			for (int j = 0; j < 4; j++) begin
				nk[w * 4 + j] = rk_q[w * 4 + j] ^ nk[(w - 1) * 4 + j] ^ mask_in_q ^ mtp[j];
			end
		end
	end

	// round datapath: add key, masked subbytes with shiftrows, remask, mix
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) ak[r * 4 + c] = st_q[r * 4 + c] ^ rk_q[c * 4 + r];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				ss[r * 4 + c] = sbox_m(ak[r * 4 + (c + r) % 4], mask_in_q, mask_out_q);
				fin[r * 4 + c] = ss[r * 4 + c] ^ nk[c * 4 + r];
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) mcol[r] = ss[r * 4 + c] ^ mt[r] ^ mask_out_q;
			mcol = mix_col(mcol);
			for (int r = 0; r < 4; r++) mixed[r * 4 + c] = mcol[r];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q  <= KEY_HIGH_RST;
			key_low_q   <= KEY_LOW_RST;
			mask_in_q   <= MASK_IN_RST;
			mask_out_q  <= MASK_OUT_RST;
			row_masks_q <= ROW_MASKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_HIGH:  key_high_q  <= cfg_data;
				REG_KEY_LOW:   key_low_q   <= cfg_data;
				REG_MASK_IN:   mask_in_q   <= cfg_data[7:0];
				REG_MASK_OUT:  mask_out_q  <= cfg_data[7:0];
				REG_ROW_MASKS: row_masks_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// round sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) out_valid_q <= 1'b1;
			else if (out_acc) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_RUN;
						rnd_q   <= '0;
					end
				end
				S_RUN: begin
					if (!last) begin
						rnd_q <= rnd_q + 4'd1;
					end else if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// block state, round key and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_q <= in_blk;
			rk_q <= key0;
		end else if (state_q == S_RUN && !last) begin
			st_q <= mixed;
			rk_q <= nk;
		end
		if (done) begin
			for (int k = 0; k < 8; k++) begin
				cipher_high_q[63 - 8 * k -: 8] <= fin[(k % 4) * 4 + k / 4];
				cipher_low_q[63 - 8 * k -: 8]  <= fin[(k % 4) * 4 + (k + 8) / 4];
			end
		end
	end

`ifndef SYNTH
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> rnd_q <= LAST_ROUND)
		else $error("round counter out of range");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_RUN && rnd_q == 4'd0)
		else $error("request did not start the round unit");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q && state_q == S_IDLE)
		else $error("finished block not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !done)
		else $error("result overwritten while stalled");
`endif

endmodule

// ===== tb/sv/maes_block_checker.sv =====
module maes_block_checker import maes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	output int          errors,
	output int          pending,
	output int          blocks_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// the masks cancel in the block, so only the key shapes the ciphertext
	logic [63:0]  key_hi, key_lo;
	logic [127:0] cipher_q [$];

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// plain aes-128 over a column-major byte array
	function automatic logic [127:0] aes128_cipher(input logic [127:0] key,
		input logic [127:0] pt);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] sh [16];
		logic [7:0] t [4];
		logic [7:0] a0, a1, a2, a3, rc;
		logic [127:0] res;
		rc = 8'h01;
		for (int k = 0; k < 16; k++) begin
			rk[k] = key[127 - 8 * k -: 8];
			st[k] = pt[127 - 8 * k -: 8];
		end
		// key schedule, word by word
		for (int w = 4; w < 44; w++) begin
			for (int j = 0; j < 4; j++) t[j] = rk[(w - 1) * 4 + j];
			if (w % 4 == 0) begin
				for (int j = 0; j < 4; j++) t[j] = SBOX[rk[(w - 1) * 4 + (j + 1) % 4]];
				t[0] = t[0] ^ rc;
				rc = xtime(rc);
			end
			for (int j = 0; j < 4; j++) rk[w * 4 + j] = rk[(w - 4) * 4 + j] ^ t[j];
		end
		for (int k = 0; k < 16; k++) st[k] = st[k] ^ rk[k];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			// sub bytes and shift rows
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++) sh[c * 4 + r] = SBOX[st[((c + r) % 4) * 4 + r]];
			// mix columns except in the last round
			for (int c = 0; c < 4; c++) begin
				a0 = sh[c * 4]; a1 = sh[c * 4 + 1]; a2 = sh[c * 4 + 2]; a3 = sh[c * 4 + 3];
				if (rnd < 10) begin
					sh[c * 4]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
					sh[c * 4 + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
					sh[c * 4 + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
					sh[c * 4 + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
				end
			end
			for (int k = 0; k < 16; k++) st[k] = sh[k] ^ rk[rnd * 16 + k];
		end
		for (int k = 0; k < 16; k++) res[127 - 8 * k -: 8] = st[k];
		return res;
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// track the key registers, predict on each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			key_hi <= KEY_HIGH_RST;
			key_lo <= KEY_LOW_RST;
			errors = 0;
			pending = 0;
			blocks_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_HIGH: key_hi <= cfg_data;
					REG_KEY_LOW:  key_lo <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				cipher_q.push_back(aes128_cipher({key_hi, key_lo}, {plain_high, plain_low}));
				pending++;
			end
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					report("unexpected result", 64'h0, cipher_high);
				end else begin
					want = cipher_q.pop_front();
					pending--;
					blocks_checked++;
					if (cipher_high !== want[127:64]) report("cipher_high", want[127:64], cipher_high);
					if (cipher_low !== want[63:0]) report("cipher_low", want[63:0], cipher_low);
				end
			end
		end
	end

endmodule

// ===== tb/sv/masked_aes128_encrypt_unit_tb.sv =====
module masked_aes128_encrypt_unit_tb import maes_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_KEY_HIGH;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] plain_high = '0;
	logic [63:0] plain_low = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	int errors, pending, blocks_checked;
	int sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit holdoff_req = 1'b0;

	masked_aes128_encrypt_unit uut (.*);

	maes_block_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver stall: random bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (holdoff_req) begin
				out_stall <= 1'b1;
				holdoff_req = 1'b0;
				repeat (120) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every result, then let the round unit settle
	task automatic drain();
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		bit taken;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		plain_high <= hi;
		plain_low <= lo;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic set_all(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] mi,
		input logic [63:0] mo, input logic [63:0] rm);
		in_valid <= 1'b0;
		drain();
		cfg_write(REG_KEY_HIGH, kh);
		cfg_write(REG_KEY_LOW, kl);
		cfg_write(REG_MASK_IN, mi);
		cfg_write(REG_MASK_OUT, mo);
		cfg_write(REG_ROW_MASKS, rm);
		settings_used++;
	endtask

	initial begin
		logic [63:0] kh;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes and walking patterns
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(64'h8000000000000000, 64'h0000000000000001);
		send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

		// standard test key, zero masks
		set_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, '0);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block('1, '0);

		// all-ones key and masks, upper bits on narrow registers ignored
		set_all('1, '1, '1, '1, '1);
		send_block('0, '1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210);

		// zero key with odd masks
		set_all('0, '0, 64'hffffffffffffff00, 64'h5a, 64'hffffffff000000ff);
		send_block('0, '0);
		send_block('1, '1);

		// writes beyond the register list change nothing
		in_valid <= 1'b0;
		drain();
		cfg_write(3'd5, '1);
		cfg_write(3'd6, 64'h1234);
		cfg_write(3'd7, '1);
		send_block(64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978);
		send_block('0, 64'h1);

		// random phases with fresh key and masks
		for (int ph = 0; ph < 8; ph++) begin
			kh = {$urandom, $urandom};
			set_all(kh, {$urandom, $urandom}, 64'($urandom), 64'($urandom), 64'($urandom));
			if (ph == 3) holdoff_req = 1'b1;
			if (ph == 7) quiet = 1'b1;
			for (int n = 0; n < 48; n++) send_block({$urandom, $urandom}, {$urandom, $urandom});
		end

		// end of stimulus
		in_valid <= 1'b0;
		drain();
		$display("ran %0d blocks over %0d key and mask settings, %0d results checked",
			sent, settings_used, blocks_checked);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/maes_pkg.sv
src/masked_aes128_encrypt_unit.sv
tb/sv/maes_block_checker.sv
tb/sv/masked_aes128_encrypt_unit_tb.sv
